// File: rtl/core/sobel_edge_magnitude_inverted_defines.svh
// Assertion macros for the Sobel edge block checker.
`ifndef SOBEL_EDGE_MAGNITUDE_INVERTED_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_INVERTED_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SEM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sem_pkg.sv
// Shared constants for the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

    localparam int PIX_BITS       = 8;
    localparam int GRAD_BITS      = 11;
    localparam int SUM_BITS       = 21;
    localparam int ROW_BITS       = 12;
    localparam int HEIGHT_BITS    = 13;
    localparam int MAX_HEIGHT     = 4096;
    localparam int HEIGHT_RESET   = 2160;
    localparam int DIM_MIN        = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'hFF;

endpackage

`default_nettype wire

// File: rtl/core/sem_linebuf.sv
// Two-row line buffer: one entry per column holds both older rows.
`default_nettype none

module sem_linebuf
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output logic      [2*PIX_BITS-1:0]        o_rd_data,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  wire logic [2*PIX_BITS-1:0]        i_wr_data
);

    // upper byte: row two above, lower byte: row one above
    logic [2*PIX_BITS-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/sem_mag.sv
// Gradient magnitude: sum of squares, then a bit-serial saturating square root.
`default_nettype none

module sem_mag
    import sem_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [GRAD_BITS-1:0] i_gv,
    input  wire logic signed [GRAD_BITS-1:0] i_gh,
    output logic                             o_done,
    output logic        [PIX_BITS-1:0]       o_root
);

    logic signed [2*GRAD_BITS-1:0] sq_v;
    logic signed [2*GRAD_BITS-1:0] sq_h;
    logic        [PIX_BITS-1:0]    trial;
    logic        [2*PIX_BITS-1:0]  trial_sq;
    logic                          sat;

    logic [SUM_BITS-1:0] r_sum;
    logic [PIX_BITS-1:0] r_root;
    logic [2:0]          r_cnt;
    logic                r_busy;
    logic                r_done;

    assign sq_v     = i_gv * i_gv;
    assign sq_h     = i_gh * i_gh;
    assign trial    = r_root | (PIX_BITS'(1) << r_cnt);
    assign trial_sq = (2*PIX_BITS)'(trial) * (2*PIX_BITS)'(trial);
    assign sat      = |r_sum[SUM_BITS-1:2*PIX_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one result bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum  <= SUM_BITS'($unsigned(sq_v)) + SUM_BITS'($unsigned(sq_h));
            r_root <= '0;
            r_cnt  <= 3'd7;
        end else if (r_busy) begin
            if (SUM_BITS'(trial_sq) <= r_sum) begin
                r_root <= trial;
            end
            r_cnt <= r_cnt - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = sat ? PIX_MAX : r_root;

endmodule

`default_nettype wire

// File: rtl/core/sobel_edge_magnitude_inverted.sv
// Top level of the streaming Sobel edge detector with inverted magnitude.
// Usage:
//   Input channel (i_valid / o_ready) carries one word per step: i_cmd = 0 with a grey
//   pixel in raster order, or i_cmd = 1 as a drain tick. Output channel (o_valid /
//   i_ready) carries 255 minus the saturated Sobel magnitude, 255 on the frame border,
//   with o_frame_last on the final word of a frame. Results lag the input by one row
//   plus one pixel; the trailing width+1 words come out on the next input words
//   (a pixel sent while they are pending is dropped).
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes frame_width at
//   index 0 and frame_height at index 1; a write restarts the frame position. Write
//   only while the block is idle.
// Throughput: one word at a time. o_valid rises after an interior pixel is accepted
//   through window shift, gradients, root load, 8 bit-serial root steps, result latch
//   and output load; a border pixel goes through window shift and output load, a pending
//   drain word through output load only; the input reopens at that same edge. A pixel
//   without result only passes the window shift; a drain tick with none pending is ignored.
// Reset: synchronous, clears the frame position, pending count and window; the line
//   buffer is not cleared. A stalled output word is held in the output register while
//   the next input word is processed; that word then waits until the register frees.
`default_nettype none

module sobel_edge_magnitude_inverted
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_cmd,
    input  wire logic [PIX_BITS-1:0]       i_pixel_in,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic      [PIX_BITS-1:0]       o_edge_out,
    output logic                           o_frame_last,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int PW      = $clog2(MAX_WIDTH + 2);
    localparam int W_RESET = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WIN  = 6'b000010,
        S_GRAD = 6'b000100,
        S_SQR  = 6'b001000,
        S_MAG  = 6'b010000,
        S_PUSH = 6'b100000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [WW-1:0]         r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [AW-1:0]         r_col;
    logic [AW-1:0]         r_addr;
    logic [ROW_BITS-1:0]   r_row;
    logic [PW-1:0]         r_pending;
    logic [PIX_BITS-1:0]   r_pix;
    logic                  r_emit;
    logic                  r_border;
    logic [PIX_BITS-1:0]   r_res_edge;
    logic                  r_res_last;
    logic [PIX_BITS-1:0]   r_win [3][3];
    logic signed [GRAD_BITS-1:0] r_gv;
    logic signed [GRAD_BITS-1:0] r_gh;
    logic                  r_out_valid;
    logic [PIX_BITS-1:0]   r_out_edge;
    logic                  r_out_last;

    logic                  in_fire;
    logic                  cfg_fire;
    logic                  pend_any;
    logic                  pix_fire;
    logic                  out_free;
    logic [WW-1:0]         col_inc;
    logic [HEIGHT_BITS-1:0] row_inc;
    logic                  emit;
    logic                  border;
    logic [2*PIX_BITS-1:0] rd_data;
    logic [PIX_BITS+1:0]   sum_top;
    logic [PIX_BITS+1:0]   sum_bot;
    logic [PIX_BITS+1:0]   sum_lft;
    logic [PIX_BITS+1:0]   sum_rgt;
    logic                  mag_done;
    logic [PIX_BITS-1:0]   mag_root;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid && o_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign pend_any    = (r_pending != '0);
    assign pix_fire    = in_fire && !pend_any && !i_cmd;
    assign out_free    = !r_out_valid || i_ready;

    assign col_inc = WW'(r_col) + WW'(1);
    assign row_inc = HEIGHT_BITS'(r_row) + HEIGHT_BITS'(1);

    // no result until the first row and one pixel are in; border whenever the
    // centre sits in the first or last column or in the first row
    assign emit   = !((r_row == '0) || (r_row == ROW_BITS'(1) && r_col == '0));
    assign border = (r_col <= AW'(1)) || (r_row <= ROW_BITS'(1));

    // Each access reads a column at accept and writes it back in the cycle after;
    // the next read waits for the state machine, so the two never collide.
    sem_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (pix_fire),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_WIN),
        .i_wr_addr (r_addr),
        .i_wr_data ({rd_data[PIX_BITS-1:0], r_pix})
    );

    sem_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQR),
        .i_gv    (r_gv),
        .i_gh    (r_gh),
        .o_done  (mag_done),
        .o_root  (mag_root)
    );

    // kernel row and column sums over the current window
    assign sum_top = (PIX_BITS+2)'(r_win[0][0]) + ((PIX_BITS+2)'(r_win[0][1]) << 1)
                   + (PIX_BITS+2)'(r_win[0][2]);
    assign sum_bot = (PIX_BITS+2)'(r_win[2][0]) + ((PIX_BITS+2)'(r_win[2][1]) << 1)
                   + (PIX_BITS+2)'(r_win[2][2]);
    assign sum_lft = (PIX_BITS+2)'(r_win[0][0]) + ((PIX_BITS+2)'(r_win[1][0]) << 1)
                   + (PIX_BITS+2)'(r_win[2][0]);
    assign sum_rgt = (PIX_BITS+2)'(r_win[0][2]) + ((PIX_BITS+2)'(r_win[1][2]) << 1)
                   + (PIX_BITS+2)'(r_win[2][2]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && pend_any) begin
                    n_state = S_PUSH;
                end else if (pix_fire) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                if (!r_emit) begin
                    n_state = S_IDLE;
                end else if (r_border) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_GRAD;
                end
            end
            S_GRAD: n_state = S_SQR;
            S_SQR:  n_state = S_MAG;
            S_MAG: begin
                if (mag_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control: state, registers, frame position, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WW'(W_RESET);
            r_height    <= HEIGHT_BITS'(HEIGHT_RESET);
            r_col       <= '0;
            r_row       <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_fire && (i_cfg_index == REG_FRAME_WIDTH ||
                             i_cfg_index == REG_FRAME_HEIGHT)) begin
                // restart the frame position on any register write
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    if (i_cfg_data < CFG_DATA_BITS'(DIM_MIN)) begin
                        r_width <= WW'(DIM_MIN);
                    end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(i_cfg_data);
                    end
                end else begin
                    if (i_cfg_data < CFG_DATA_BITS'(DIM_MIN)) begin
                        r_height <= HEIGHT_BITS'(DIM_MIN);
                    end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                        r_height <= HEIGHT_BITS'(MAX_HEIGHT);
                    end else begin
                        r_height <= HEIGHT_BITS'(i_cfg_data);
                    end
                end
                r_col     <= '0;
                r_row     <= '0;
                r_pending <= '0;
            end else if (in_fire && pend_any) begin
                r_pending <= r_pending - PW'(1);
            end else if (pix_fire) begin
                if (col_inc == r_width) begin
                    r_col <= '0;
                    if (row_inc == r_height) begin
                        // frame done: queue the trailing border words
                        r_row     <= '0;
                        r_pending <= PW'(r_width) + PW'(1);
                    end else begin
                        r_row <= ROW_BITS'(row_inc);
                    end
                end else begin
                    r_col <= AW'(col_inc);
                end
            end

            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window, gradients and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (r_state == S_WIN) begin
            // advance the window one column, new column from the line buffer
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= rd_data[2*PIX_BITS-1:PIX_BITS];
            r_win[1][2] <= rd_data[PIX_BITS-1:0];
            r_win[2][2] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_pix    <= i_pixel_in;
            r_addr   <= r_col;
            r_emit   <= emit;
            r_border <= border;
        end

        if (in_fire && pend_any) begin
            r_res_edge <= PIX_MAX;
            r_res_last <= (r_pending == PW'(1));
        end else if (r_state == S_WIN) begin
            r_res_edge <= PIX_MAX;
            r_res_last <= 1'b0;
        end else if (r_state == S_MAG && mag_done) begin
            r_res_edge <= PIX_MAX - mag_root;
            r_res_last <= 1'b0;
        end

        if (r_state == S_GRAD) begin
            r_gv <= $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
            r_gh <= $signed({1'b0, sum_lft}) - $signed({1'b0, sum_rgt});
        end

        if (r_state == S_PUSH && out_free) begin
            r_out_edge <= r_res_edge;
            r_out_last <= r_res_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_out   = r_out_edge;
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

// File: rtl/core/sem_checker.sv
// Port-level checker for the Sobel edge block and its bind.
`default_nettype none

`include "sobel_edge_magnitude_inverted_defines.svh"

module sem_checker
    import sem_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic                i_cmd,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire logic [PIX_BITS-1:0] o_edge_out,
    input wire logic                o_frame_last
);

    // the flagged word of a frame is always a border word
    `SEM_ASSERT_SAME(a_last_is_border, o_valid && o_frame_last, o_edge_out == PIX_MAX, "frame_last word is not 255")

    // a pixel word, taken as a pixel or as a pending drain word, keeps the input closed in the next cycle
    `SEM_ASSERT_NEXT(a_busy_after_pixel, i_valid && o_ready && !i_cmd, !o_ready, "input reopened right after a pixel word")

    // a stalled output word holds
    `SEM_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_edge_out) && $stable(o_frame_last), "stalled output word changed")

endmodule

bind sobel_edge_magnitude_inverted sem_checker u_sem_checker (.*);

`default_nettype wire
